>>> sv/aabb_collision_pushout_unit_macros.svh
// Assertion macros for the box collision push-out unit.
// Used by the checker module; needs clk and rst in scope.
`ifndef AABB_COLLISION_PUSHOUT_UNIT_MACROS_SVH
`define AABB_COLLISION_PUSHOUT_UNIT_MACROS_SVH

// check a property outside reset
`define AP_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every edge, reset included
`define AP_CHECK_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/aabbp_pkg.sv
// Shared types and constants for the box collision push-out unit.
// No dependencies.
`timescale 1ns / 1ps

package aabbp_pkg;

  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = 14;
  localparam int QUO_W      = DIV_BITS * DIV_STAGES;
  localparam int CLAMP_LOG2 = 40;
  localparam int LANES      = 8;

  typedef struct packed {
    logic               static_pair;
    logic               push_enable;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] moving_top;
    logic signed [31:0] moving_bottom;
    logic signed [31:0] moving_right;
    logic signed [31:0] moving_left;
    logic signed [31:0] static_top;
    logic signed [31:0] static_bottom;
    logic signed [31:0] static_right;
    logic signed [31:0] static_left;
  } item_t;

endpackage

>>> sv/aabb_collision_pushout_unit.sv
// Top level of the box collision push-out unit: overlap test and push-out.
// Depends on aabbp_pkg and aabbp_div.
//
//  channel | dir | tdata                               | tuser
//  s_*     | in  | sL,sR,sB,sT,mL,mR,mB,mT,vel_x,vel_y | push_enable,static_pair
//  m_*     | out | new_x,new_y                         | collided,moved
//
// One item enters per cycle unless a stalled output has filled the pipeline; the stages are
// input, difference, multiply, 14 divider stages, corner evaluation and output.
// The depth is set by the ray intercept divider, 3 quotient bits per stage.
// Reset clears all stage valid bits; payload is not reset.
// Each stage holds only while full and its successor holds, so bubbles close up
// and a stalled output still lets items enter.
`timescale 1ns / 1ps

module aabb_collision_pushout_unit import aabbp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // static_left, static_right, static_bottom, static_top, moving_left,
  // moving_right, moving_bottom, moving_top, vel_x, vel_y
  input  logic [319:0] s_tdata,
  // push_enable, static_pair
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_x, new_y
  output logic [63:0]  m_tdata,
  // collided, moved
  output logic [1:0]   m_tuser
);

  localparam int ST_DIFF = 1;
  localparam int ST_MUL  = 2;
  localparam int ST_DIV0 = 3;
  localparam int ST_EVAL = ST_DIV0 + DIV_STAGES;
  localparam int ST_OUT  = ST_EVAL + 1;
  localparam int NST     = ST_OUT + 1;

  function automatic logic signed [32:0] sx(logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic signed [31:0] x_line(item_t it);
    return (it.vel_x > 0) ? it.static_left : it.static_right;
  endfunction

  function automatic logic signed [31:0] y_line(item_t it);
    return (it.vel_y > 0) ? it.static_bottom : it.static_top;
  endfunction

  function automatic logic signed [31:0] corner_x(item_t it, logic [1:0] k);
    return k[0] ? it.moving_right : it.moving_left;
  endfunction

  function automatic logic signed [31:0] corner_y(item_t it, logic [1:0] k);
    return k[1] ? it.moving_top : it.moving_bottom;
  endfunction

  function automatic logic [31:0] mag33(logic signed [32:0] v);
    return v[32] ? 32'(-v) : v[31:0];
  endfunction

  function automatic logic signed [31:0] sat45(logic signed [44:0] v);
    if (v > 45'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -45'sh0_8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  logic [NST-1:0] vld;
  logic [NST-1:0] en;
  item_t          side [ST_OUT];
  item_t          in_item;

  assign in_item  = item_t'({s_tuser, s_tdata});
  assign s_tready = en[0];
  assign m_tvalid = vld[ST_OUT];

  always_comb begin
    en[NST-1] = !vld[NST-1] || m_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= s_tvalid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) side[0] <= in_item;
    for (int k = 1; k < ST_OUT; k++) begin
      if (en[k]) side[k] <= side[k-1];
    end
  end

  // difference stage: distances from corners to the facing lines
  logic [31:0] magd [LANES];
  logic [31:0] magvx, magvy;

  always_ff @(posedge clk) begin
    if (en[ST_DIFF]) begin
      for (int k = 0; k < 4; k++) begin
        magd[k]   <= mag33(sx(y_line(side[0])) - sx(corner_y(side[0], 2'(k))));
        magd[k+4] <= mag33(sx(x_line(side[0])) - sx(corner_x(side[0], 2'(k))));
      end
      magvx <= mag33(sx(side[0].vel_x));
      magvy <= mag33(sx(side[0].vel_y));
    end
  end

  // multiply stage
  logic [63:0] prod [LANES];
  logic [31:0] dv   [LANES];

  always_ff @(posedge clk) begin
    if (en[ST_MUL]) begin
      for (int k = 0; k < LANES; k++) begin
        prod[k] <= magd[k] * ((k < 4) ? magvx : magvy);
        dv[k]   <= (k < 4) ? magvy : magvx;
      end
    end
  end

  logic [QUO_W-1:0] quo [LANES];
  logic             qovf [LANES];

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    aabbp_div u_div (
      .clk      (clk),
      .en       (en[ST_DIV0 +: DIV_STAGES]),
      .dividend (prod[l]),
      .divisor  (dv[l]),
      .quotient (quo[l]),
      .ovf      (qovf[l])
    );
  end

  // evaluation stage: intercepts, hit tests, non-diagonal position
  logic signed [42:0] xr [4];
  logic signed [42:0] yr [4];
  logic [3:0]         okx, oky;
  logic signed [33:0] ndx, ndy;
  logic               diag;

  logic signed [42:0] xr_next [4];
  logic signed [42:0] yr_next [4];
  logic [3:0]         okx_next, oky_next;
  logic signed [33:0] ndx_next, ndy_next;

  always_comb begin : eval
    item_t              it;
    logic [QUO_W-1:0]   qmax;
    logic [CLAMP_LOG2:0] qc;
    logic signed [32:0] d;
    logic signed [41:0] off;
    logic               neg, zero, vxp, vyp;
    it   = side[ST_EVAL-1];
    qmax = QUO_W'(1) << CLAMP_LOG2;
    vxp  = it.vel_x > 0;
    vyp  = it.vel_y > 0;
    for (int k = 0; k < LANES; k++) begin
      qc = (qovf[k] || quo[k] > qmax) ? (CLAMP_LOG2+1)'(qmax) : quo[k][CLAMP_LOG2:0];
      if (k < 4) begin
        d    = sx(y_line(it)) - sx(corner_y(it, 2'(k)));
        zero = (d == 0) || (it.vel_x == 0);
      end else begin
        d    = sx(x_line(it)) - sx(corner_x(it, 2'(k - 4)));
        zero = (d == 0) || (it.vel_y == 0);
      end
      neg = d[32] ^ vxp ^ vyp;
      if (zero) off = '0;
      else if (neg) off = -$signed({1'b0, qc});
      else off = $signed({1'b0, qc});
      if (k < 4) begin
        xr_next[k]  = 43'(sx(corner_x(it, 2'(k)))) + 43'(off);
        okx_next[k] = (43'(sx(it.static_left)) <= xr_next[k]) &&
                      (xr_next[k] <= 43'(sx(it.static_right))) &&
                      ((vxp && off <= 0) || (it.vel_x < 0 && off >= 0));
      end else begin
        yr_next[k-4]  = 43'(sx(corner_y(it, 2'(k - 4)))) + 43'(off);
        oky_next[k-4] = (43'(sx(it.static_bottom)) <= yr_next[k-4]) &&
                        (yr_next[k-4] <= 43'(sx(it.static_top))) &&
                        ((vyp && off <= 0) || (it.vel_y < 0 && off >= 0));
      end
    end
  end

  always_comb begin : nondiag
    item_t              it;
    logic signed [33:0] w, h, x_lo, y_lo;
    logic signed [34:0] dl, dr, db, dt, al, ar, ab, at;
    it   = side[ST_EVAL-1];
    w    = 34'(sx(it.moving_right)) - 34'(sx(it.moving_left));
    h    = 34'(sx(it.moving_top)) - 34'(sx(it.moving_bottom));
    x_lo = 34'(sx(it.static_left)) - w;
    y_lo = 34'(sx(it.static_bottom)) - h;
    dl   = 35'(sx(it.static_left)) * 2 - 35'(sx(it.moving_left)) - 35'(sx(it.moving_right));
    dr   = 35'(sx(it.static_right)) * 2 - 35'(sx(it.moving_left)) - 35'(sx(it.moving_right));
    db   = 35'(sx(it.static_bottom)) * 2 - 35'(sx(it.moving_bottom)) - 35'(sx(it.moving_top));
    dt   = 35'(sx(it.static_top)) * 2 - 35'(sx(it.moving_bottom)) - 35'(sx(it.moving_top));
    al   = dl[34] ? -dl : dl;
    ar   = dr[34] ? -dr : dr;
    ab   = db[34] ? -db : db;
    at   = dt[34] ? -dt : dt;
    if (it.vel_x == 0 && it.vel_y == 0) begin
      ndx_next = (al <= ar) ? x_lo : 34'(sx(it.static_right));
      ndy_next = (ab <= at) ? y_lo : 34'(sx(it.static_top));
    end else if (it.vel_x == 0) begin
      ndx_next = 34'(sx(it.moving_left));
      ndy_next = (it.vel_y > 0) ? y_lo : 34'(sx(it.static_top));
    end else begin
      ndy_next = 34'(sx(it.moving_bottom));
      ndx_next = (it.vel_x > 0) ? x_lo : 34'(sx(it.static_right));
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_EVAL]) begin
      xr   <= xr_next;
      yr   <= yr_next;
      okx  <= okx_next;
      oky  <= oky_next;
      ndx  <= ndx_next;
      ndy  <= ndy_next;
      diag <= (side[ST_EVAL-1].vel_x != 0) && (side[ST_EVAL-1].vel_y != 0);
    end
  end

  // output stage: first hit, corner adjust, saturate
  logic               hit, moved;
  logic signed [31:0] new_x_next, new_y_next;
  logic               out_coll, out_moved;
  logic signed [31:0] out_x, out_y;

  always_comb begin : select
    item_t              it;
    logic [1:0]         corner;
    logic signed [42:0] hx, hy;
    logic signed [44:0] w, h, px, py, hy_alt;
    logic               on_y;
    it = side[ST_EVAL];
    hit = (it.static_left < it.moving_right) && (it.moving_left < it.static_right) &&
          (it.static_bottom < it.moving_top) && (it.moving_bottom < it.static_top);
    moved = hit && it.push_enable && it.static_pair;
    corner = 2'd0;
    hx = '0;
    hy = '0;
    for (int k = 3; k >= 0; k--) begin
      if (okx[k]) begin
        corner = 2'(k);
        hx     = xr[k];
        hy     = 43'(sx(y_line(it)));
      end else if (oky[k]) begin
        corner = 2'(k);
        hx     = 43'(sx(x_line(it)));
        hy     = yr[k];
      end
    end
    w      = 45'(sx(it.moving_right)) - 45'(sx(it.moving_left));
    h      = 45'(sx(it.moving_top)) - 45'(sx(it.moving_bottom));
    on_y   = corner[1] ? (hy == 43'(sx(it.static_top))) : (hy == 43'(sx(it.static_bottom)));
    hy_alt = corner[1] ? (on_y ? 45'(hy) : 45'(hy) - h) : (on_y ? 45'(hy) - h : 45'(hy));
    if (corner[0]) begin
      if (hx == 43'(sx(it.static_right))) begin
        px = 45'(hx);
        py = corner[1] ? 45'(hy) - h : 45'(hy);
      end else begin
        px = 45'(hx) - w;
        py = hy_alt;
      end
    end else begin
      if (hx == 43'(sx(it.static_left))) begin
        px = 45'(hx) - w;
        py = corner[1] ? 45'(hy) - h : 45'(hy);
      end else begin
        px = 45'(hx);
        py = hy_alt;
      end
    end
    if (!diag) begin
      px = 45'(ndx);
      py = 45'(ndy);
    end
    new_x_next = moved ? sat45(px) : '0;
    new_y_next = moved ? sat45(py) : '0;
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      out_coll  <= hit;
      out_moved <= moved;
      out_x     <= new_x_next;
      out_y     <= new_y_next;
    end
  end

  assign m_tdata = {out_y, out_x};
  assign m_tuser = {out_moved, out_coll};

endmodule

>>> sv/aabbp_div.sv
// Pipelined unsigned restoring divider, a few quotient bits per stage.
// Depends on aabbp_pkg; stage enables come from the parent pipeline.
`timescale 1ns / 1ps

module aabbp_div import aabbp_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [63:0]           dividend,
  input  logic [31:0]           divisor,
  output logic [QUO_W-1:0]      quotient,
  output logic                  ovf
);

  logic [31:0]      rem_q  [DIV_STAGES];
  logic [QUO_W-1:0] lo_q   [DIV_STAGES];
  logic [QUO_W-1:0] quo_q  [DIV_STAGES];
  logic [31:0]      dv_q   [DIV_STAGES];
  logic             ovf_q  [DIV_STAGES];

  logic [31:0]      rem_in [DIV_STAGES];
  logic [QUO_W-1:0] lo_in  [DIV_STAGES];
  logic [QUO_W-1:0] quo_in [DIV_STAGES];
  logic [31:0]      dv_in  [DIV_STAGES];
  logic             ovf_in [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign rem_in[s] = 32'(dividend[63:QUO_W]);
      assign lo_in[s]  = dividend[QUO_W-1:0];
      assign quo_in[s] = '0;
      assign dv_in[s]  = divisor;
      assign ovf_in[s] = 32'(dividend[63:QUO_W]) >= divisor;
    end else begin : g_next
      assign rem_in[s] = rem_q[s-1];
      assign lo_in[s]  = lo_q[s-1];
      assign quo_in[s] = quo_q[s-1];
      assign dv_in[s]  = dv_q[s-1];
      assign ovf_in[s] = ovf_q[s-1];
    end

    logic [31:0]      rem_next;
    logic [QUO_W-1:0] lo_next;
    logic [QUO_W-1:0] quo_next;

    always_comb begin : step
      logic [32:0] t;
      rem_next = rem_in[s];
      lo_next  = lo_in[s];
      quo_next = quo_in[s];
      for (int j = 0; j < DIV_BITS; j++) begin
        t       = {rem_next, lo_next[QUO_W-1]};
        lo_next = {lo_next[QUO_W-2:0], 1'b0};
        if (t >= {1'b0, dv_in[s]}) begin
          rem_next = 32'(t - {1'b0, dv_in[s]});
          quo_next = {quo_next[QUO_W-2:0], 1'b1};
        end else begin
          rem_next = t[31:0];
          quo_next = {quo_next[QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_q[s] <= rem_next;
        lo_q[s]  <= lo_next;
        quo_q[s] <= quo_next;
        dv_q[s]  <= dv_in[s];
        ovf_q[s] <= ovf_in[s];
      end
    end
  end

  assign quotient = quo_q[DIV_STAGES-1];
  assign ovf      = ovf_q[DIV_STAGES-1];

endmodule

>>> sv/aabbp_checker.sv
// Port-level checker for the box collision push-out unit, bound to the top.
// Depends on aabb_collision_pushout_unit_macros.svh.
`timescale 1ns / 1ps
`include "aabb_collision_pushout_unit_macros.svh"

module aabbp_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [319:0] s_tdata,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [63:0]  m_tdata,
  input logic [1:0]   m_tuser
);

  `AP_CHECK(a_moved_needs_hit, m_tvalid |-> (!m_tuser[1] || m_tuser[0]), "moved without overlap")
  `AP_CHECK(a_idle_pos_zero, (m_tvalid && !m_tuser[1]) |-> (m_tdata == 64'd0), "position not zero")
  `AP_CHECK_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "output valid after reset")
  `AP_CHECK(a_hold_output, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)), "output dropped")
  `AP_CHECK(a_ready_when_free, (m_tready || !m_tvalid) |-> s_tready, "input blocked with room")

endmodule

bind aabb_collision_pushout_unit aabbp_checker u_checker (.*);

>>> verif/aabb_collision_pushout_checker.sv
// Checker for the box collision push-out unit: predicts each result from the input
// transfers and compares it with the output transfers. Depends on aabbp_pkg.
`timescale 1ns / 1ps

module aabb_collision_pushout_checker import aabbp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [319:0] s_tdata,
  input  logic [1:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [63:0]  m_tdata,
  input  logic [1:0]   m_tuser,
  output int           errors,
  output int           pending
);

  typedef struct packed {
    logic        collided;
    logic        moved;
    logic [31:0] new_x;
    logic [31:0] new_y;
  } pushout_t;

  pushout_t pushouts_q[$];

  localparam longint RAY_LIMIT = 64'sd1 << CLAMP_LOG2;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic longint ray_offset(longint d, longint num, longint den);
    logic        neg;
    logic [63:0] p;
    logic [63:0] q;
    longint      r;
    neg = ((d < 0) != (num < 0)) != (den < 0);
    p = 64'(mag(d)) * 64'(mag(num));
    q = p / 64'(mag(den));
    if (d == 0 || num == 0) return 0;
    r = (q > 64'(RAY_LIMIT)) ? RAY_LIMIT : longint'(q);
    return neg ? -r : r;
  endfunction

  function automatic pushout_t predict_pushout(item_t it);
    pushout_t res;
    longint sl, sr, sb, st, ml, mr, mb, mt, vx, vy, w, h, px, py;
    longint ix, iy, xl, yl, hx, hy, cx, cy, xr, yr, c2x, c2y;
    int     corner;
    logic   hit;
    sl = it.static_left;   sr = it.static_right;
    sb = it.static_bottom; st = it.static_top;
    ml = it.moving_left;   mr = it.moving_right;
    mb = it.moving_bottom; mt = it.moving_top;
    vx = it.vel_x;         vy = it.vel_y;
    hit = sl < mr && ml < sr && sb < mt && mb < st;
    res.collided = hit;
    res.moved = hit && it.push_enable && it.static_pair;
    w = mr - ml;
    h = mt - mb;
    px = 0;
    py = 0;
    if (res.moved) begin
      if (vx == 0 && vy == 0) begin
        c2x = ml + mr;
        c2y = mb + mt;
        px = (mag(2 * sl - c2x) <= mag(2 * sr - c2x)) ? sl - w : sr;
        py = (mag(2 * sb - c2y) <= mag(2 * st - c2y)) ? sb - h : st;
      end else if (vx == 0) begin
        px = ml;
        py = (vy > 0) ? sb - h : st;
      end else if (vy == 0) begin
        py = mb;
        px = (vx > 0) ? sl - w : sr;
      end else begin
        ix = -vx;
        iy = -vy;
        xl = ix < 0 ? sl : sr;
        yl = iy < 0 ? sb : st;
        hx = 0;
        hy = 0;
        corner = 0;
        for (int k = 0; k < 4; k++) begin
          cx = k[0] ? mr : ml;
          cy = k[1] ? mt : mb;
          xr = cx + ray_offset(yl - cy, ix, iy);
          yr = cy + ray_offset(xl - cx, iy, ix);
          if (sl <= xr && xr <= sr && ((ix < 0 && xr <= cx) || (ix > 0 && xr >= cx))) begin
            corner = k; hx = xr; hy = yl;
            break;
          end
          if (sb <= yr && yr <= st && ((iy < 0 && yr <= cy) || (iy > 0 && yr >= cy))) begin
            corner = k; hx = xl; hy = yr;
            break;
          end
        end
        px = corner[0] ? hx - w : hx;
        py = corner[1] ? hy - h : hy;
        if (corner[0]) begin
          if (hx == sr) px += w;
          else if (corner[1] ? hy == st : hy == sb) py += corner[1] ? h : -h;
        end else begin
          if (hx == sl) px -= w;
          else if (corner[1] ? hy == st : hy == sb) py += corner[1] ? h : -h;
        end
      end
    end
    res.new_x = res.moved ? sat32(px) : 32'h0;
    res.new_y = res.moved ? sat32(py) : 32'h0;
    return res;
  endfunction

  assign pending = pushouts_q.size();

  always @(posedge clk) begin
    pushout_t exp_r;
    pushout_t act_r;
    if (rst) begin
      errors = 0;
    end else begin
      if (s_tvalid && s_tready)
        pushouts_q.push_back(predict_pushout(item_t'({s_tuser, s_tdata})));
      if (m_tvalid && m_tready) begin
        act_r = {m_tuser[0], m_tuser[1], m_tdata[31:0], m_tdata[63:32]};
        if (pushouts_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none actual %h", $time, act_r);
        end else begin
          exp_r = pushouts_q.pop_front();
          if (exp_r.collided !== act_r.collided) begin
            errors++;
            $display("%0t collided: expected %b actual %b", $time, exp_r.collided,
                     act_r.collided);
          end
          if (exp_r.moved !== act_r.moved) begin
            errors++;
            $display("%0t moved: expected %b actual %b", $time, exp_r.moved, act_r.moved);
          end
          if (exp_r.new_x !== act_r.new_x) begin
            errors++;
            $display("%0t new_x: expected %h actual %h", $time, exp_r.new_x, act_r.new_x);
          end
          if (exp_r.new_y !== act_r.new_y) begin
            errors++;
            $display("%0t new_y: expected %h actual %h", $time, exp_r.new_y, act_r.new_y);
          end
        end
      end
    end
  end

endmodule

>>> verif/tb_aabb_collision_pushout_unit.sv
// Testbench top for the box collision push-out unit: drives directed and random box
// pairs with random idling and a long output stall. Depends on aabbp_pkg and the checker.
`timescale 1ns / 1ps

module tb_aabb_collision_pushout_unit;
  import aabbp_pkg::*;

  localparam int RANDOM_ITEMS = 690;

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [319:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [63:0]  m_tdata;
  logic [1:0]   m_tuser;
  int           errors;
  int           pending;
  int           phase = 0;
  logic         hold_req = 0;

  always #4 clk = ~clk;

  aabb_collision_pushout_unit dut (.*);

  aabb_collision_pushout_checker chk (.*);

  function automatic int send_idle_pct();
    return phase == 0 ? 7 : (phase == 1 ? 54 : 0);
  endfunction

  function automatic int recv_idle_pct();
    return phase == 0 ? 54 : (phase == 1 ? 7 : 0);
  endfunction

  function automatic item_t make_box_pair(int sl, int sr, int sb, int st, int ml, int mr,
                                          int mb, int mt, int vx, int vy, bit en, bit pr);
    item_t it;
    it.static_left = sl;   it.static_right = sr;
    it.static_bottom = sb; it.static_top = st;
    it.moving_left = ml;   it.moving_right = mr;
    it.moving_bottom = mb; it.moving_top = mt;
    it.vel_x = vx;         it.vel_y = vy;
    it.push_enable = en;   it.static_pair = pr;
    return it;
  endfunction

  function automatic int rand_vel();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: return $urandom_range(1, 4) << 16;
      default: return int'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  function automatic item_t random_box_pair();
    item_t it;
    int    base, sw, sh;
    if ($urandom_range(0, 9) == 0) begin
      it = {2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
      return it;
    end
    base = $urandom_range(0, 3) == 0 ? int'($urandom) : int'($urandom_range(0, 32'h00ff_ffff));
    sw = $urandom_range(1, 32'h0010_0000);
    sh = $urandom_range(1, 32'h0010_0000);
    it.static_left = base;
    it.static_right = base + sw;
    it.static_bottom = base - sh;
    it.static_top = base;
    it.moving_left = it.static_left + int'($urandom_range(0, 2 * sw)) - sw;
    it.moving_right = it.moving_left + int'($urandom_range(1, 32'h0010_0000));
    it.moving_bottom = it.static_bottom + int'($urandom_range(0, 2 * sh)) - sh;
    it.moving_top = it.moving_bottom + int'($urandom_range(1, 32'h0010_0000));
    if ($urandom_range(0, 15) == 0) it.moving_right = it.moving_left - 32'h100;
    it.vel_x = rand_vel();
    it.vel_y = rand_vel();
    it.push_enable = $urandom_range(0, 7) != 0;
    it.static_pair = $urandom_range(0, 7) != 0;
    return it;
  endfunction

  task automatic send_box_pair(item_t it);
    while ($urandom_range(0, 99) < send_idle_pct()) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    {s_tuser, s_tdata} <= it;
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 0;
        repeat (300) @(posedge clk);
        hold_req = 0;
      end
      m_tready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct());
    end
  end

  initial begin
    item_t directed_q[$];
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed_q = '{
      make_box_pair(0, 'h40000, 0, 'h40000, 'h10000, 'h30000, 'h10000, 'h30000, 0, 0, 1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h30000, 'h50000, 'h28000, 'h50000, 0, 0, 1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h10000, 'h30000, 'h10000, 'h30000, 0, 'h10000,
                    1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h10000, 'h30000, 'h10000, 'h30000, 0, -'h10000,
                    1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h10000, 'h30000, 'h10000, 'h30000, 'h10000, 0,
                    1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h10000, 'h30000, 'h10000, 'h30000, -'h10000, 0,
                    1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, -'h8000, 'h10000, 'h30000, 'h48000, 'h10000,
                    -'h20000, 1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h30000, 'h48000, -'h8000, 'h8000, -'h20000,
                    'h10000, 1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h10000, 'h30000, 'h10000, 'h30000, 'h10000,
                    'h10000, 1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h10000, 'h30000, 'h10000, 'h30000, 1, 1, 1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h10000, 'h30000, 'h10000, 'h30000, 0, 0, 0, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h10000, 'h30000, 'h10000, 'h30000, 0, 0, 1, 0),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h40000, 'h50000, 'h10000, 'h30000, 0, 0, 1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h10000, 'h30000, 'h40000, 'h50000, 0, 0, 1, 1),
      make_box_pair(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                    32'sh80000001, 32'sh7ffffffe, 32'sh80000001, 32'sh7ffffffe, 0, 0, 1, 1),
      make_box_pair(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                    32'sh80000001, 32'sh7ffffffe, 32'sh80000001, 32'sh7ffffffe,
                    32'sh7fffffff, 32'sh80000000, 1, 1),
      make_box_pair(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                    -1, 1, -1, 1, 32'sh80000000, 32'sh7fffffff, 1, 1),
      make_box_pair(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                    -1, 1, -1, 1, 32'sh80000000, 0, 1, 1),
      make_box_pair('h40000, 0, 0, 'h40000, 'h10000, 'h30000, 'h10000, 'h30000, 0, 0, 1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h30000, 'h10000, 'h30000, 'h10000, 'h10000,
                    'h10000, 1, 1),
      make_box_pair(0, 'h40000, 0, 'h40000, 'h100000, 'h200000, 'h100000, 'h200000,
                    'h10000, 'h10000, 1, 1),
      make_box_pair(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 1, 1)
    };
    foreach (directed_q[i]) send_box_pair(directed_q[i]);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) phase = 1;
      if (n == 2 * RANDOM_ITEMS / 3) begin
        phase = 2;
        hold_req = 1;
      end
      send_box_pair(random_box_pair());
    end
    s_tvalid <= 0;
    while (pending != 0 || hold_req) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
